/* src/tpe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle plane equation package
// Shared widths and step counts for the normalization datapath.
// ----------------------------------------------------------------------------
package tpe_pkg;

    // Normalized magnitude width: largest component lies in [2^30, 2^31)
    localparam int NORM_W     = 31;
    // Sum of squares and vector length
    localparam int SUM_W      = 64;
    localparam int LEN_W      = 32;
    // One root bit per pipeline stage, one quotient bit per pipeline stage
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;
    // Quotient numerator: magnitude scaled by 2^30 plus half the length
    localparam int NUM_W      = 62;
    // Output field widths
    localparam int TAG_W      = 24;
    localparam int NRM_W      = 32;
    localparam int OFF_W      = 25;
    localparam int FRAC_SH    = 30;

endpackage

/* src/tpe_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module tpe_sqrt (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [tpe_pkg::SUM_W-1:0]  rad,
    output logic [tpe_pkg::LEN_W-1:0]  root
);
    import tpe_pkg::*;

    localparam int REM_W = LEN_W + 2;

    logic [SUM_W-1:0] v_reg [SQRT_STEPS+1];
    logic [REM_W-1:0] r_reg [SQRT_STEPS+1];
    logic [LEN_W-1:0] q_reg [SQRT_STEPS+1];

    // Stage zero is the raw radicand
    always_comb begin
        v_reg[0] = rad;
        r_reg[0] = '0;
        q_reg[0] = '0;
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [REM_W+1:0] rr;
        logic [REM_W+1:0] trial;
        logic [REM_W-1:0] r_next;
        logic [LEN_W-1:0] q_next;

        // Bring down two radicand bits, try root*4+1
        always_comb begin
            rr    = {r_reg[k], v_reg[k][SUM_W-1 -: 2]};
            trial = (REM_W+2)'({q_reg[k], 2'b01});
            if (rr >= trial) begin
                r_next = REM_W'(rr - trial);
                q_next = {q_reg[k][LEN_W-2:0], 1'b1};
            end else begin
                r_next = REM_W'(rr);
                q_next = {q_reg[k][LEN_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[k+1] <= {v_reg[k][SUM_W-3:0], 2'b00};
                r_reg[k+1] <= r_next;
                q_reg[k+1] <= q_next;
            end
        end
    end

    assign root = q_reg[SQRT_STEPS];

endmodule

/* src/tpe_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Quotient of a 62-bit numerator by a 32-bit divisor, one bit per stage.
// The quotient must fit 32 bits (numerator < divisor * 2^32).
// ----------------------------------------------------------------------------
module tpe_div (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [tpe_pkg::NUM_W-1:0]  num,
    input  logic [tpe_pkg::LEN_W-1:0]  den,
    output logic [tpe_pkg::LEN_W-1:0]  quo
);
    import tpe_pkg::*;

    logic [LEN_W-1:0] rem_reg [DIV_STEPS+1];
    logic [LEN_W-1:0] low_reg [DIV_STEPS+1];
    logic [LEN_W-1:0] den_reg [DIV_STEPS+1];
    logic [LEN_W-1:0] q_reg   [DIV_STEPS+1];

    // Upper numerator bits start as the partial remainder
    always_comb begin
        rem_reg[0] = LEN_W'(num[NUM_W-1:LEN_W]);
        low_reg[0] = num[LEN_W-1:0];
        den_reg[0] = den;
        q_reg[0]   = '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [LEN_W:0]   rr;
        logic [LEN_W-1:0] rem_next;
        logic             qbit;

        // Shift in next numerator bit, subtract when it fits
        always_comb begin
            rr = {rem_reg[k], low_reg[k][LEN_W-1]};
            if (rr >= {1'b0, den_reg[k]}) begin
                rem_next = LEN_W'(rr - {1'b0, den_reg[k]});
                qbit     = 1'b1;
            end else begin
                rem_next = LEN_W'(rr);
                qbit     = 1'b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= rem_next;
                low_reg[k+1] <= {low_reg[k][LEN_W-2:0], 1'b0};
                den_reg[k+1] <= den_reg[k];
                q_reg[k+1]   <= {q_reg[k][LEN_W-2:0], qbit};
            end
        end
    end

    assign quo = q_reg[DIV_STEPS];

endmodule

/* src/triangle_plane_equation.sv */
`timescale 1ns / 1ps
// Throughput: one triangle per cycle unless the output stalls; the 32-stage
// square root and the 32-stage dividers each retire one item per cycle.
// A stalled output freezes the whole pipeline in place; nothing is dropped.
// Reset (aresetn low, synchronous) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// Triangle plane equation
// Computes unit normal (Q1.30) and plane offset (Q12.12) of a triangle.
// ----------------------------------------------------------------------------
module triangle_plane_equation #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // tri_tag, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic [((24+9*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // tag_out, normal_x, normal_y, normal_z, plane_offset
    output logic [151:0]                                m_tdata,
    // plane_valid
    output logic [0:0]                                  m_tuser
);
    import tpe_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int ES     = (W > 30) ? (W - 30) : 0;
    localparam int EW     = W + 1 - ES;
    localparam int PW     = 2 * EW;
    localparam int BL_W   = $clog2(PW + 1);
    localparam int DW     = W + 34;
    localparam int SIDE_D = 3 + SQRT_STEPS + 1 + DIV_STEPS + 3;
    localparam int NSTG   = 4 + SIDE_D + 1;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [3*W-1:0]    va;
        logic [2:0]        sgn;
        logic              degen;
    } side_t;

    logic en;
    logic [NSTG-1:0] vld_reg;

    // Global advance: hold everything while the result waits
    assign en       = ~vld_reg[NSTG-1] | m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // Stage 1: edges
    logic [TAG_W-1:0]    tag1_reg;
    logic [3*W-1:0]      va1_reg;
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];

    for (genvar k = 0; k < 3; k++) begin : g_edge
        logic signed [W-1:0] av, bv, cv;
        logic signed [W:0]   d1, d2;
        always_comb begin
            av = s_tdata[TAG_W + k*W +: W];
            bv = s_tdata[TAG_W + (3+k)*W +: W];
            cv = s_tdata[TAG_W + (6+k)*W +: W];
            d1 = (W+1)'($signed({bv[W-1], bv}) - $signed({av[W-1], av}));
            d2 = (W+1)'($signed({cv[W-1], cv}) - $signed({av[W-1], av}));
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                e1_reg[k] <= EW'(d1 >>> ES);
                e2_reg[k] <= EW'(d2 >>> ES);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag1_reg <= s_tdata[TAG_W-1:0];
            va1_reg  <= s_tdata[TAG_W +: 3*W];
        end
    end

    // Stage 2: cross product terms
    logic [TAG_W-1:0]     tag2_reg;
    logic [3*W-1:0]       va2_reg;
    logic signed [PW-1:0] p_reg [6];

    always_ff @(posedge aclk) begin
        if (en) begin
            tag2_reg <= tag1_reg;
            va2_reg  <= va1_reg;
            p_reg[0] <= e1_reg[1] * e2_reg[2];
            p_reg[1] <= e1_reg[2] * e2_reg[1];
            p_reg[2] <= e1_reg[2] * e2_reg[0];
            p_reg[3] <= e1_reg[0] * e2_reg[2];
            p_reg[4] <= e1_reg[0] * e2_reg[1];
            p_reg[5] <= e1_reg[1] * e2_reg[0];
        end
    end

    // Stage 3: cross product, sign and magnitude
    logic [TAG_W-1:0] tag3_reg;
    logic [3*W-1:0]   va3_reg;
    logic [PW-1:0]    mag3_reg [3];
    logic [2:0]       sgn3_reg;

    for (genvar k = 0; k < 3; k++) begin : g_cross
        logic signed [PW:0] cr;
        always_comb begin
            cr = $signed({p_reg[2*k][PW-1], p_reg[2*k]})
               - $signed({p_reg[2*k+1][PW-1], p_reg[2*k+1]});
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sgn3_reg[k] <= cr[PW];
                mag3_reg[k] <= cr[PW] ? PW'(-cr) : PW'(cr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag3_reg <= tag2_reg;
            va3_reg  <= va2_reg;
        end
    end

    // Stage 4: bit length of the largest magnitude (same as of their OR)
    logic [PW-1:0]   or_mag;
    logic [BL_W-1:0] bl;
    logic [PW-1:0]   mag4_reg [3];
    logic [BL_W-1:0] bl4_reg;
    side_t           side4_reg;

    always_comb begin
        or_mag = mag3_reg[0] | mag3_reg[1] | mag3_reg[2];
        bl     = '0;
        for (int i = 0; i < PW; i++) begin
            if (or_mag[i]) begin
                bl = BL_W'(i + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag4_reg        <= mag3_reg;
            bl4_reg         <= bl;
            side4_reg.tag   <= tag3_reg;
            side4_reg.va    <= va3_reg;
            side4_reg.sgn   <= sgn3_reg;
            side4_reg.degen <= (or_mag == '0);
        end
    end

    // Stage 5: normalize so the largest magnitude lands in [2^30, 2^31)
    logic [NORM_W-1:0] nm5_reg [3];

    for (genvar k = 0; k < 3; k++) begin : g_norm
        logic [PW+NORM_W-1:0] wide;
        always_comb begin
            wide = {mag4_reg[k], {NORM_W{1'b0}}} >> bl4_reg;
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                nm5_reg[k] <= wide[NORM_W-1:0];
            end
        end
    end

    // Stage 6: squares
    logic [2*NORM_W-1:0] sq6_reg [3];
    logic [NORM_W-1:0]   nm6_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            nm6_reg <= nm5_reg;
            for (int k = 0; k < 3; k++) begin
                sq6_reg[k] <= nm5_reg[k] * nm5_reg[k];
            end
        end
    end

    // Stage 7: sum of squares
    logic [SUM_W-1:0]  sum7_reg;
    logic [NORM_W-1:0] nm7_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            nm7_reg  <= nm6_reg;
            sum7_reg <= SUM_W'(sq6_reg[0]) + SUM_W'(sq6_reg[1]) + SUM_W'(sq6_reg[2]);
        end
    end

    // Length: pipelined square root
    logic [LEN_W-1:0]  len;
    logic [NORM_W-1:0] nmd_reg [SQRT_STEPS][3];

    tpe_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (sum7_reg),
        .root (len)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            nmd_reg[0] <= nm7_reg;
            for (int i = 1; i < SQRT_STEPS; i++) begin
                nmd_reg[i] <= nmd_reg[i-1];
            end
        end
    end

    // Quotient operands: mag * 2^30 + len / 2 over len
    logic [NUM_W-1:0] num_reg [3];
    logic [LEN_W-1:0] den_reg;
    logic [LEN_W-1:0] quo [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= len;
            for (int k = 0; k < 3; k++) begin
                num_reg[k] <= NUM_W'({nmd_reg[SQRT_STEPS-1][k], {FRAC_SH{1'b0}}})
                            + NUM_W'(len >> 1);
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_div
        tpe_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (num_reg[k]),
            .den  (den_reg),
            .quo  (quo[k])
        );
    end

    // Side data rides alongside from stage 5 to the output stage
    side_t side_reg [SIDE_D];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side4_reg;
            for (int i = 1; i < SIDE_D; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Saturate to one and apply sign
    localparam logic [LEN_W-1:0] ONE_Q30 = LEN_W'(1) << FRAC_SH;
    logic signed [NRM_W-1:0] nrm_reg [3];
    side_t side_n;

    assign side_n = side_reg[SIDE_D-4];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (side_n.sgn[k]) begin
                    nrm_reg[k] <= -$signed((quo[k] > ONE_Q30) ? ONE_Q30 : quo[k]);
                end else begin
                    nrm_reg[k] <= $signed((quo[k] > ONE_Q30) ? ONE_Q30 : quo[k]);
                end
            end
        end
    end

    // Offset products
    side_t side_p;
    logic signed [W+NRM_W-1:0] prod_reg [3];
    logic signed [NRM_W-1:0]   nrmp_reg [3];

    assign side_p = side_reg[SIDE_D-3];

    always_ff @(posedge aclk) begin
        if (en) begin
            nrmp_reg <= nrm_reg;
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= $signed(side_p.va[k*W +: W]) * nrm_reg[k];
            end
        end
    end

    // Dot sum
    logic signed [DW-1:0]    dot_reg;
    logic signed [NRM_W-1:0] nrms_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            nrms_reg <= nrmp_reg;
            dot_reg  <= DW'(prod_reg[0]) + DW'(prod_reg[1]) + DW'(prod_reg[2]);
        end
    end

    // Round half away, negate, saturate
    localparam logic signed [DW-1:0] OFF_MAX = (DW'(1) <<< (OFF_W-1)) - DW'(1);
    localparam logic signed [DW-1:0] OFF_MIN = -(DW'(1) <<< (OFF_W-1));
    logic [DW-1:0]        adot;
    logic signed [DW-1:0] offv;
    logic [OFF_W-1:0]     off_sat;
    side_t                side_o;

    assign side_o = side_reg[SIDE_D-1];

    always_comb begin
        adot = dot_reg[DW-1] ? DW'(-dot_reg) : DW'(dot_reg);
        adot = (adot + (DW'(1) << (FRAC_SH-1))) >> FRAC_SH;
        offv = dot_reg[DW-1] ? $signed(adot) : -$signed(adot);
        if (offv > OFF_MAX) begin
            off_sat = OFF_W'(OFF_MAX);
        end else if (offv < OFF_MIN) begin
            off_sat = OFF_W'(OFF_MIN);
        end else begin
            off_sat = OFF_W'(offv);
        end
    end

    // Output register
    logic [151:0] tdata_reg;
    logic         pvalid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pvalid_reg <= ~side_o.degen;
            if (side_o.degen) begin
                tdata_reg <= {{(152-TAG_W){1'b0}}, side_o.tag};
            end else begin
                tdata_reg <= {7'b0, off_sat, nrms_reg[2], nrms_reg[1], nrms_reg[0],
                              side_o.tag};
            end
        end
    end

    assign m_tvalid   = vld_reg[NSTG-1];
    assign m_tdata    = tdata_reg;
    assign m_tuser[0] = pvalid_reg;

    // A degenerate result carries zero normal and offset
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[151:TAG_W] == '0)
        else $error("degenerate result with nonzero plane");

    // A valid normal's x component never exceeds one in magnitude
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            $signed(m_tdata[55:24]) <= $signed(ONE_Q30) &&
            $signed(m_tdata[55:24]) >= -$signed(ONE_Q30))
        else $error("normal x out of range");

    // Pipeline holds every valid bit while stalled
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during stall");

    // Input side is ready whenever the result slot is free
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

/* test/tpe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle plane equation checker
// Watches both streams, predicts normal and offset per triangle, compares.
// ----------------------------------------------------------------------------
module tpe_checker #(
    parameter int COORD_WIDTH = 24,
    parameter int IN_W        = ((24+9*COORD_WIDTH+7)/8)*8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic            m_tvalid,
    input  logic            m_tready,
    input  logic [151:0]    m_tdata,
    input  logic [0:0]      m_tuser,
    output int              fail_count,
    output int              pending
);
    import tpe_pkg::*;

    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic signed [OFF_W-1:0] offset;
        logic                    valid;
    } plane_t;

    plane_t plane_q[$];

    localparam int EDGE_SH = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;

    // Integer square root, floor
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res, bit_w;
        res   = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic plane_t plane_of(input logic [IN_W-1:0] d);
        plane_t p;
        longint va[3], e1[3], e2[3], cr[3], nrm[3];
        longint bv, cv, dotp, off;
        logic [63:0] mag[3], big, sum, len, q, adot;
        int bl;
        p = '0;
        p.tag = d[TAG_W-1:0];
        for (int k = 0; k < 3; k++) begin
            va[k] = longint'($signed(d[TAG_W + k*COORD_WIDTH +: COORD_WIDTH]));
            bv = longint'($signed(d[TAG_W + (3+k)*COORD_WIDTH +: COORD_WIDTH]));
            cv = longint'($signed(d[TAG_W + (6+k)*COORD_WIDTH +: COORD_WIDTH]));
            e1[k] = (bv - va[k]) >>> EDGE_SH;
            e2[k] = (cv - va[k]) >>> EDGE_SH;
        end
        cr[0] = e1[1]*e2[2] - e1[2]*e2[1];
        cr[1] = e1[2]*e2[0] - e1[0]*e2[2];
        cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
        big = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = (cr[k] < 0) ? -cr[k] : cr[k];
            if (mag[k] > big) big = mag[k];
        end
        if (big == 0) return p;
        bl = 0;
        while ((big >> bl) != 0) bl++;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            if (bl > 31) mag[k] = mag[k] >> (bl - 31);
            else         mag[k] = mag[k] << (31 - bl);
            sum += mag[k] * mag[k];
        end
        len = root_floor(sum);
        for (int k = 0; k < 3; k++) begin
            q = ((mag[k] << FRAC_SH) + (len >> 1)) / len;
            if (q > (64'd1 << 30)) q = 64'd1 << 30;
            nrm[k] = (cr[k] < 0) ? -longint'(q) : longint'(q);
        end
        dotp = va[0]*nrm[0] + va[1]*nrm[1] + va[2]*nrm[2];
        adot = (dotp < 0) ? -dotp : dotp;
        adot = (adot + (64'd1 << 29)) >> 30;
        off  = (dotp < 0) ? longint'(adot) : -longint'(adot);
        if (off > (1 << 24) - 1) off = (1 << 24) - 1;
        if (off < -(1 << 24))    off = -(1 << 24);
        p.nx = NRM_W'(nrm[0]);
        p.ny = NRM_W'(nrm[1]);
        p.nz = NRM_W'(nrm[2]);
        p.offset = OFF_W'(off);
        p.valid = 1'b1;
        return p;
    endfunction

    // Predict on every input transaction, compare on every output transaction
    always @(posedge aclk) begin
        plane_t exp_p, got;
        if (!aresetn) begin
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (s_tvalid && s_tready) plane_q.push_back(plane_of(s_tdata));
            if (m_tvalid && m_tready) begin
                got = {m_tdata[23:0], m_tdata[55:24], m_tdata[87:56],
                       m_tdata[119:88], m_tdata[144:120], m_tuser[0]};
                if (plane_q.size() == 0) begin
                    $error("result with no triangle outstanding, tag %0h", got.tag);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_p = plane_q.pop_front();
                    if (got !== exp_p) begin
                        fail_count <= fail_count + 1;
                        if (got.tag !== exp_p.tag)
                            $error("tag_out exp %0h got %0h", exp_p.tag, got.tag);
                        if (got.nx !== exp_p.nx)
                            $error("normal_x exp %0d got %0d", exp_p.nx, got.nx);
                        if (got.ny !== exp_p.ny)
                            $error("normal_y exp %0d got %0d", exp_p.ny, got.ny);
                        if (got.nz !== exp_p.nz)
                            $error("normal_z exp %0d got %0d", exp_p.nz, got.nz);
                        if (got.offset !== exp_p.offset)
                            $error("plane_offset exp %0d got %0d",
                                   exp_p.offset, got.offset);
                        if (got.valid !== exp_p.valid)
                            $error("plane_valid exp %0b got %0b",
                                   exp_p.valid, got.valid);
                    end
                end
            end
            pending <= plane_q.size();
        end
    end
endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle plane equation testbench
// Directed corner triangles, then random ones under bursty input and stalls.
// ----------------------------------------------------------------------------
module tb;
    localparam int CW   = 24;
    localparam int IN_W = ((24+9*CW+7)/8)*8;
    localparam int N_RANDOM = 1530;
    localparam int IDLE_LIMIT = 5000;

    logic            aclk;
    logic            aresetn;
    logic            s_tvalid;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [151:0]    m_tdata;
    logic [0:0]      m_tuser;
    int              fail_count;
    int              pending;
    int              idle_cycles = 0;
    logic            stall_mode = 1'b0;

    triangle_plane_equation #(.COORD_WIDTH(CW)) u_dut (.*);

    tpe_checker #(.COORD_WIDTH(CW)) u_check (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog: cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver stalls: alternates between free-running and choppy stretches
    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
        m_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    function automatic logic [CW-1:0] rand_coord(input int mode);
        case (mode)
            0: return CW'($urandom);
            1: return $urandom_range(0, 1) ? {1'b1, {(CW-1){1'b0}}}
                                           : {1'b0, {(CW-1){1'b1}}};
            default: return CW'($signed($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    // Hold one triangle until accepted
    task automatic send_tri(input logic [IN_W-1:0] d);
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_idle(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    function automatic logic [IN_W-1:0] pack_tri(input logic [23:0] tag,
                                                 input logic [CW-1:0] v[9]);
        logic [IN_W-1:0] d;
        d = '0;
        d[23:0] = tag;
        for (int k = 0; k < 9; k++) d[24 + k*CW +: CW] = v[k];
        return d;
    endfunction

    initial begin
        logic [CW-1:0] v[9];
        logic [CW-1:0] mx, mn;
        int burst, mode;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        aresetn = 0; s_tvalid = 0; s_tdata = '0;
        repeat (2) @(negedge aclk);
        aresetn = 1;

        // Degenerate: all vertices equal, collinear, and a zero triangle
        v = '{default: 0};
        send_tri(pack_tri(24'hFFFFFF, v));
        v = '{default: mx};
        send_tri(pack_tri(24'h000001, v));
        v = '{0, 0, 0, 4096, 4096, 4096, 8192, 8192, 8192};
        send_tri(pack_tri(24'h000002, v));
        // Axis-aligned unit triangles in the xy and yz planes and both windings
        v = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_tri(pack_tri(24'h000003, v));
        v = '{0, 0, 0, 0, 4096, 0, 4096, 0, 0};
        send_tri(pack_tri(24'h000004, v));
        v = '{0, 0, 4096, 0, 4096, 4096, 0, 0, 8192};
        send_tri(pack_tri(24'h000005, v));
        v = '{4096, 0, 0, 4096, 0, 4096, 4096, 4096, 0};
        send_tri(pack_tri(24'h000006, v));
        // Extreme coordinates: widest edges, offset saturation
        v = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
        send_tri(pack_tri(24'hAAAAAA, v));
        v = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};
        send_tri(pack_tri(24'h555555, v));
        v = '{mx, mx, mx, mx, mx, mn, mx, mn, mx};
        send_tri(pack_tri(24'h800000, v));
        v = '{mn, mx, mn, mx, mn, mx, mn, mn, mx};
        send_tri(pack_tri(24'h7FFFFF, v));
        // Tiny edges: one LSB
        v = '{mx, mn, 0, mx - 1, mn, 0, mx, mn + 1, 0};
        send_tri(pack_tri(24'h00000F, v));
        v = '{123, -77, 5, 124, -77, 5, 123, -77, 6};
        send_tri(pack_tri(24'h0000F0, v));

        // Let the pipe drain before the random part
        send_idle(1);
        while (pending != 0) @(negedge aclk);

        for (int i = 0; i < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && i < N_RANDOM; j++, i++) begin
                mode = $urandom_range(0, 9);
                for (int k = 0; k < 9; k++)
                    v[k] = rand_coord(mode < 6 ? 0 : (mode < 7 ? 1 : 2));
                if (mode == 9) begin
                    // degenerate: repeated vertex
                    v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
                end
                send_tri(pack_tri(24'($urandom), v));
            end
            if ($urandom_range(0, 2) == 0) send_idle($urandom_range(1, 30));
            if (i == N_RANDOM / 2) begin
                send_idle(1);
                while (pending != 0) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

/* sim.f */
src/tpe_pkg.sv
src/tpe_sqrt.sv
src/tpe_div.sv
src/triangle_plane_equation.sv
test/tpe_checker.sv
test/tb.sv
